// ----- rtl/keyed_channel_history_store_core_defines.svh -----
// Assertion macros for the keyed channel history store.
// Included by the modules that carry assertions; expands to nothing in synthesis.
`ifndef KEYED_CHANNEL_HISTORY_STORE_CORE_DEFINES_SVH
`define KEYED_CHANNEL_HISTORY_STORE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define KCHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KCHS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KCHS_ASSERT(lbl, prop, msg)
`define KCHS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/kchs_pkg.sv -----
// Shared constants, types and ring arithmetic for the keyed channel history store.
// No dependencies.
package kchs_pkg;

  localparam int CHANNELS    = 8;
  localparam int RING_DEPTH  = 32;
  localparam int KEY_BYTES   = 8;
  localparam int MAX_RESULTS = 32;

  localparam int SLOT_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W      = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);
  localparam int CNT_W      = 6;
  localparam int CHCNT_W    = $clog2(CHANNELS + 1);
  localparam int CMP_A_W    = (FILL_W > CHCNT_W) ? FILL_W : CHCNT_W;
  localparam int CMP_W      = (CMP_A_W > CNT_W) ? CMP_A_W : CNT_W;
  localparam int HIST_DEPTH = CHANNELS * RING_DEPTH;
  localparam int ADDR_W     = $clog2(HIST_DEPTH);

  localparam logic [63:0] KEY_MASK =
    (KEY_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

  localparam logic STATUS_DATA = 1'b0;
  localparam logic STATUS_NONE = 1'b1;

  typedef enum logic [1:0] {
    KIND_PUBLISH = 2'd0,
    KIND_LATEST  = 2'd1,
    KIND_HISTORY = 2'd2,
    KIND_LIST    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] channel_key;
    logic [63:0] unit_code;
    logic [31:0] sample_bits;
    logic [62:0] time_stamp;
    logic [5:0]  max_count;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [63:0] out_key;
    logic [63:0] out_unit;
    logic [31:0] out_value;
    logic [62:0] out_time;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0] value;
    logic [63:0] unit;
    logic [62:0] stamp;
  } hist_entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    hist_entry_t       wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic              we;
    logic              claim;
    logic [SLOT_W-1:0] slot;
    logic [63:0]       key;
    logic [63:0]       unit;
  } slot_upd_t;

  typedef struct packed {
    logic              used;
    logic [63:0]       key;
    logic [63:0]       unit;
    logic [POS_W-1:0]  head;
    logic [FILL_W-1:0] fill;
  } slot_view_t;

  function automatic logic [POS_W-1:0] pos_next(logic [POS_W-1:0] pos);
    return (pos == POS_W'(RING_DEPTH - 1)) ? '0 : pos + POS_W'(1);
  endfunction

  function automatic logic [POS_W-1:0] pos_prev(logic [POS_W-1:0] pos);
    return (pos == '0) ? POS_W'(RING_DEPTH - 1) : pos - POS_W'(1);
  endfunction

  function automatic logic [POS_W-1:0] pos_oldest(logic [POS_W-1:0] head,
                                                  logic [FILL_W-1:0] fill);
    logic [POS_W:0] s;
    s = (POS_W + 1)'(head) + (POS_W + 1)'(RING_DEPTH) - (POS_W + 1)'(fill);
    if (s >= (POS_W + 1)'(RING_DEPTH)) begin
      s = s - (POS_W + 1)'(RING_DEPTH);
    end
    return s[POS_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] hist_addr(logic [SLOT_W-1:0] slot,
                                                  logic [POS_W-1:0] pos);
    return ADDR_W'(ADDR_W'(slot) * ADDR_W'(RING_DEPTH) + ADDR_W'(pos));
  endfunction

endpackage

// ----- rtl/kchs_hist_ram.sv -----
// Sample history memory: one write port, one registered read port.
// Depends on kchs_pkg.
module kchs_hist_ram (
  input  logic                      clk,
  input  kchs_pkg::ram_req_t        ram,
  output kchs_pkg::hist_entry_t     rdata
);
  import kchs_pkg::*;

  hist_entry_t hist_mem [HIST_DEPTH];
  hist_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (ram.we) begin
      hist_mem[ram.waddr] <= ram.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ram.re) begin
      rdata_r <= hist_mem[ram.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/kchs_slot_table.sv -----
// Channel slot table: used flags, keys, units, ring head and fill per slot.
// Depends on kchs_pkg.
module kchs_slot_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kchs_pkg::slot_upd_t         upd,
  input  logic [kchs_pkg::SLOT_W-1:0] rd_slot,
  output kchs_pkg::slot_view_t        view,
  output logic [kchs_pkg::CHANNELS-1:0] used_vec
);
  import kchs_pkg::*;

  logic [CHANNELS-1:0] used_r;
  logic [63:0]         key_r  [CHANNELS];
  logic [63:0]         unit_r [CHANNELS];
  logic [POS_W-1:0]    head_r [CHANNELS];
  logic [FILL_W-1:0]   fill_r [CHANNELS];

  logic [POS_W-1:0]  head_nxt;
  logic [FILL_W-1:0] fill_nxt;

  always_comb begin
    if (upd.claim) begin
      head_nxt = pos_next('0);
      fill_nxt = FILL_W'(1);
    end else begin
      head_nxt = pos_next(head_r[upd.slot]);
      fill_nxt = (fill_r[upd.slot] == FILL_W'(RING_DEPTH)) ?
                 fill_r[upd.slot] : fill_r[upd.slot] + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else if (upd.we) begin
      used_r[upd.slot] <= 1'b1;
      head_r[upd.slot] <= head_nxt;
      fill_r[upd.slot] <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.we) begin
      unit_r[upd.slot] <= upd.unit;
      if (upd.claim) begin
        key_r[upd.slot] <= upd.key;
      end
    end
  end

  assign view.used = used_r[rd_slot];
  assign view.key  = key_r[rd_slot];
  assign view.unit = unit_r[rd_slot];
  assign view.head = head_r[rd_slot];
  assign view.fill = fill_r[rd_slot];
  assign used_vec  = used_r;

endmodule

// ----- rtl/kchs_ctrl.sv -----
// Request sequencer: one shared key comparator stepped over the slots, ring
// addressing and result streaming. Depends on kchs_pkg and the defines header.
`include "keyed_channel_history_store_core_defines.svh"
module kchs_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  kchs_pkg::req_t                req,
  output logic                          busy,
  input  kchs_pkg::slot_view_t          view,
  input  logic [kchs_pkg::CHANNELS-1:0] used_vec,
  output logic [kchs_pkg::SLOT_W-1:0]   rd_slot,
  output kchs_pkg::slot_upd_t           upd,
  output kchs_pkg::ram_req_t            ram,
  input  kchs_pkg::hist_entry_t         ram_rdata,
  output logic                          out_strobe,
  output kchs_pkg::res_t                out_res
);
  import kchs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_WRITE = 7'b0000100,
    S_EMIT  = 7'b0001000,
    S_LIST  = 7'b0010000,
    S_LEMIT = 7'b0100000,
    S_EMPTY = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  req_t              req_r, req_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              claim_r, claim_nxt;
  logic              free_ok_r, free_ok_nxt;
  logic [SLOT_W-1:0] free_slot_r, free_slot_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              fzero_r, fzero_nxt;
  logic              out_strobe_r;
  res_t              out_res_r;

  logic              emit_v;
  res_t              emit_res;
  logic [63:0]       key_in;
  logic [CNT_W-1:0]  maxc_in;
  logic [CMP_W-1:0]  used_cnt;
  logic [CMP_W-1:0]  total_w;
  logic [CMP_W-1:0]  hist_w;
  logic              match;
  logic              free_now;
  logic              last_v;
  logic [POS_W-1:0]  pos_tmp;

  always_comb begin
    key_in   = req.channel_key & KEY_MASK;
    maxc_in  = (req.max_count > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : req.max_count;
    used_cnt = CMP_W'($countones(used_vec));
    total_w  = (used_cnt < CMP_W'(maxc_in)) ? used_cnt : CMP_W'(maxc_in);
    hist_w   = (CMP_W'(view.fill) < CMP_W'(req_r.max_count)) ?
               CMP_W'(view.fill) : CMP_W'(req_r.max_count);
    match    = view.used && (view.key == req_r.channel_key);
    free_now = free_ok_r || !view.used;
    last_v   = ((j_r + CNT_W'(1)) == cnt_r);
    pos_tmp  = '0;

    state_nxt     = state_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    claim_nxt     = claim_r;
    free_ok_nxt   = free_ok_r;
    free_slot_nxt = free_slot_r;
    pos_nxt       = pos_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    fzero_nxt     = fzero_r;
    rd_slot       = slot_r;
    upd           = '0;
    ram           = '0;
    emit_v        = 1'b0;
    emit_res      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt             = req;
          req_nxt.channel_key = key_in;
          req_nxt.max_count   = maxc_in;
          idx_nxt             = '0;
          free_ok_nxt         = 1'b0;
          j_nxt               = '0;
          cnt_nxt             = total_w[CNT_W-1:0];
          if (req.kind == KIND_LIST) begin
            state_nxt = (total_w == '0) ? S_EMPTY : S_LIST;
          end else if (key_in == '0) begin
            state_nxt = (req.kind == KIND_PUBLISH) ? S_IDLE : S_EMPTY;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_slot = idx_r;
        if (match) begin
          slot_nxt = idx_r;
          unique case (req_r.kind)
            KIND_PUBLISH: begin
              claim_nxt = 1'b0;
              state_nxt = S_WRITE;
            end
            KIND_LATEST: begin
              if (view.fill == '0) begin
                state_nxt = S_EMPTY;
              end else begin
                ram.re    = 1'b1;
                ram.raddr = hist_addr(idx_r, pos_prev(view.head));
                j_nxt     = '0;
                cnt_nxt   = CNT_W'(1);
                state_nxt = S_EMIT;
              end
            end
            KIND_HISTORY: begin
              if (hist_w == '0) begin
                state_nxt = S_EMPTY;
              end else begin
                pos_tmp   = pos_oldest(view.head, view.fill);
                ram.re    = 1'b1;
                ram.raddr = hist_addr(idx_r, pos_tmp);
                pos_nxt   = pos_tmp;
                j_nxt     = '0;
                cnt_nxt   = hist_w[CNT_W-1:0];
                state_nxt = S_EMIT;
              end
            end
            KIND_LIST: state_nxt = S_EMPTY;
          endcase
        end else if (idx_r == SLOT_W'(CHANNELS - 1)) begin
          if (req_r.kind == KIND_PUBLISH) begin
            if (free_now) begin
              slot_nxt  = free_ok_r ? free_slot_r : idx_r;
              claim_nxt = 1'b1;
              state_nxt = S_WRITE;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            state_nxt = S_EMPTY;
          end
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
          if (!free_ok_r && !view.used) begin
            free_ok_nxt   = 1'b1;
            free_slot_nxt = idx_r;
          end
        end
      end
      S_WRITE: begin
        upd.we          = 1'b1;
        upd.claim       = claim_r;
        upd.slot        = slot_r;
        upd.key         = req_r.channel_key;
        upd.unit        = req_r.unit_code;
        pos_tmp         = claim_r ? '0 : view.head;
        ram.we          = 1'b1;
        ram.waddr       = hist_addr(slot_r, pos_tmp);
        ram.wdata.value = req_r.sample_bits;
        ram.wdata.unit  = req_r.unit_code;
        ram.wdata.stamp = req_r.time_stamp;
        state_nxt       = S_IDLE;
      end
      S_EMIT: begin
        emit_v             = 1'b1;
        emit_res.status    = STATUS_DATA;
        emit_res.out_key   = req_r.channel_key;
        emit_res.out_unit  = ram_rdata.unit;
        emit_res.out_value = ram_rdata.value;
        emit_res.out_time  = ram_rdata.stamp;
        emit_res.last      = last_v;
        if (last_v) begin
          state_nxt = S_IDLE;
        end else begin
          pos_tmp   = pos_next(pos_r);
          pos_nxt   = pos_tmp;
          ram.re    = 1'b1;
          ram.raddr = hist_addr(slot_r, pos_tmp);
          j_nxt     = j_r + CNT_W'(1);
        end
      end
      S_LIST: begin
        rd_slot = idx_r;
        if (view.used) begin
          ram.re    = 1'b1;
          ram.raddr = hist_addr(idx_r, pos_prev(view.head));
          fzero_nxt = (view.fill == '0);
          state_nxt = S_LEMIT;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end
      S_LEMIT: begin
        rd_slot            = idx_r;
        emit_v             = 1'b1;
        emit_res.status    = STATUS_DATA;
        emit_res.out_key   = view.key;
        emit_res.out_unit  = view.unit;
        emit_res.out_value = fzero_r ? '0 : ram_rdata.value;
        emit_res.out_time  = fzero_r ? '0 : ram_rdata.stamp;
        emit_res.last      = last_v;
        j_nxt              = j_r + CNT_W'(1);
        idx_nxt            = idx_r + SLOT_W'(1);
        state_nxt          = last_v ? S_IDLE : S_LIST;
      end
      S_EMPTY: begin
        emit_v          = 1'b1;
        emit_res.status = STATUS_NONE;
        emit_res.last   = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= emit_v;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    idx_r       <= idx_nxt;
    slot_r      <= slot_nxt;
    claim_r     <= claim_nxt;
    free_ok_r   <= free_ok_nxt;
    free_slot_r <= free_slot_nxt;
    pos_r       <= pos_nxt;
    j_r         <= j_nxt;
    cnt_r       <= cnt_nxt;
    fzero_r     <= fzero_nxt;
    if (emit_v) begin
      out_res_r <= emit_res;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  `KCHS_ASSERT(a_query_busy, (start && !busy && req.kind != KIND_PUBLISH) |=> busy, "query not taken")
  `KCHS_ASSERT(a_none_last, (out_strobe_r && out_res_r.status == STATUS_NONE) |-> out_res_r.last, "empty reply not last")
  `KCHS_ASSERT(a_gap_after_last, (out_strobe_r && out_res_r.last) |=> !out_strobe_r, "result after last")
  `KCHS_ASSERT(a_claim_free, (upd.we && upd.claim) |-> !used_vec[upd.slot], "claimed a used slot")
  `KCHS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_strobe_r), "reset not idle")

endmodule

// ----- rtl/keyed_channel_history_store_core.sv -----
// Keyed channel history store: a table of channels, each with a ring of samples.
// Depends on kchs_pkg, kchs_slot_table, kchs_hist_ram and kchs_ctrl.
//
// Requests enter on in_req and are taken when start is high and busy is low.
// Publish stores a sample under its channel key and returns nothing; a zero key,
// or a new key when every slot is used, is dropped. Get latest, get history and
// list return one or more results on out_res, each valid for exactly one cycle
// with out_strobe high; the final one has last set. A request with nothing to
// return gives one result with status set and last set. The key search tests
// one slot per cycle through a single comparator; publish then writes in S_WRITE.
// History streams one sample per cycle after the first memory read; list passes
// through S_LIST and S_LEMIT per used channel and S_LIST alone per skipped slot.
// The first result comes out behind the registered history read and the output
// register. busy stays high until the final result is issued; the next request
// can be taken in the cycle that result is on the outputs. Reset empties the
// channel table; the history memory needs no clearing. The receiver cannot
// stall, so results are never held back.
module keyed_channel_history_store_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  kchs_pkg::req_t in_req,
  output logic           busy,
  output logic           out_strobe,
  output kchs_pkg::res_t out_res
);
  import kchs_pkg::*;

  slot_view_t          view;
  slot_upd_t           upd;
  logic [SLOT_W-1:0]   rd_slot;
  logic [CHANNELS-1:0] used_vec;
  ram_req_t            ram;
  hist_entry_t         ram_rdata;

  kchs_slot_table u_slot_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (upd),
    .rd_slot  (rd_slot),
    .view     (view),
    .used_vec (used_vec)
  );

  kchs_hist_ram u_hist_ram (
    .clk   (clk),
    .ram   (ram),
    .rdata (ram_rdata)
  );

  kchs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .req        (in_req),
    .busy       (busy),
    .view       (view),
    .used_vec   (used_vec),
    .rd_slot    (rd_slot),
    .upd        (upd),
    .ram        (ram),
    .ram_rdata  (ram_rdata),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule
